@@ src/otm_pkg.sv @@
package otm_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int FRAME_BITS_DEF = 48;

  localparam int SAMPLE_OFFSET_BITS = 16;
  localparam int RATE_BITS = 19;
  localparam logic [RATE_BITS-1:0] DEFAULT_RATE = 19'd48000;

  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ONSET = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_RATE = 1'b1;

  // window test: a match needs 25 * |diff| <= 3 * rate
  localparam int WIN_BITS = 24;
  localparam logic [WIN_BITS-1:0] WIN_NUM = 24'd3;
  localparam logic [WIN_BITS-1:0] WIN_DEN = 24'd25;

  // ms in Q8: |diff| * 256000 / rate, fits in 15 bits after the window test
  localparam int MS_BITS = 16;
  localparam int MS_SCALE_BITS = 18;
  localparam logic [MS_SCALE_BITS-1:0] MS_SCALE = 18'd256000;
  localparam int NUM_BITS = RATE_BITS + MS_SCALE_BITS;

endpackage

@@ src/otm_in_if.sv @@
interface otm_in_if #(
  parameter int FRAME_BITS = otm_pkg::FRAME_BITS_DEF
) ();
  logic                                    valid;
  logic                                    ready;
  logic [otm_pkg::CMD_BITS-1:0]            command;
  logic [FRAME_BITS-1:0]                   frame;
  logic [otm_pkg::SAMPLE_OFFSET_BITS-1:0]  sample_offset;
  logic                                    block_last;

  modport source (output valid, command, frame, sample_offset, block_last, input ready);
  modport sink (input valid, command, frame, sample_offset, block_last, output ready);
endinterface

@@ src/otm_out_if.sv @@
interface otm_out_if #(
  parameter int FRAME_BITS = otm_pkg::FRAME_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic signed [FRAME_BITS:0]         offset_frames;
  logic signed [otm_pkg::MS_BITS-1:0] offset_ms_q8;

  modport source (output valid, offset_frames, offset_ms_q8, input ready);
  modport sink (input valid, offset_frames, offset_ms_q8, output ready);
endinterface

@@ src/otm_ring.sv @@
module otm_ring #(
  parameter int RING_DEPTH = otm_pkg::RING_DEPTH_DEF,
  parameter int FRAME_BITS = otm_pkg::FRAME_BITS_DEF,
  localparam int ADDR_BITS = $clog2(RING_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [FRAME_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output logic [FRAME_BITS-1:0] rd_data
);

  logic [FRAME_BITS-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/otm_div.sv @@
// restoring divider, one quotient bit per cycle
module otm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [otm_pkg::NUM_BITS-1:0]     num,
  input  logic [otm_pkg::RATE_BITS-1:0]    den,
  output logic                             done,
  output logic [otm_pkg::MS_BITS-1:0]      quotient
);

  localparam int Q_BITS = otm_pkg::MS_BITS;
  localparam int N_BITS = otm_pkg::NUM_BITS;
  localparam int STEP_BITS = $clog2(Q_BITS);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [N_BITS-1:0]    rem;
  logic [N_BITS-1:0]    dsh;
  logic                 ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num;
      dsh      <= N_BITS'(den) << (Q_BITS - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[Q_BITS-2:0], ge};
      dsh      <= dsh >> 1;
    end
  end

endmodule

@@ src/onset_tick_timing_matcher_core.sv @@
// Channel  Dir  Word                                         Handshake
// in_ch    in   command, frame, sample_offset, block_last    valid/ready
// out_ch   out  offset_frames, offset_ms_q8                  valid/ready
// cfg      in   cfg_index, cfg_data                          cfg_we, no stall
//
// Tick, clear and ignored words are handled in the idle state. An onset scans k ring
// entries (k up to RING_DEPTH), read one per cycle from the single read port of the
// ring memory, then passes the check, the divider load, the divider and the output.
// An onset that is dropped ends after the check.
// Reset (rst, synchronous) clears pointer, count, last match and output valid.
// A waiting result does not block input; a new result waits for the output slot.
module onset_tick_timing_matcher_core #(
  parameter int RING_DEPTH = otm_pkg::RING_DEPTH_DEF,
  parameter int FRAME_BITS = otm_pkg::FRAME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  otm_in_if.sink                               in_ch,
  otm_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [otm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [otm_pkg::RATE_BITS-1:0]        cfg_data
);

  localparam int ADDR_BITS = $clog2(RING_DEPTH);
  localparam int CNT_BITS = $clog2(RING_DEPTH + 1);
  localparam int DIFF_BITS = FRAME_BITS + 1;
  localparam int RB = otm_pkg::RATE_BITS;
  localparam int WB = otm_pkg::WIN_BITS;
  localparam int NB = otm_pkg::NUM_BITS;
  localparam int MB = otm_pkg::MS_BITS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;

  logic                  enabled;
  logic [RB-1:0]         rate;
  logic [ADDR_BITS-1:0]  wp;
  logic [CNT_BITS-1:0]   count;
  logic [FRAME_BITS-1:0] last_matched;

  logic [FRAME_BITS-1:0] onset;
  logic [ADDR_BITS-1:0]  scan_ptr;
  logic [CNT_BITS-1:0]   scan_left;
  logic                  have;
  logic [FRAME_BITS-1:0] best_tick;
  logic [FRAME_BITS-1:0] best_abs;
  logic [DIFF_BITS-1:0]  best_diff;
  logic [NB-1:0]         num;

  logic                  out_valid;
  logic [DIFF_BITS-1:0]  out_frames;
  logic [MB-1:0]         out_ms;

  logic                  in_fire;
  logic                  out_free;
  logic [ADDR_BITS-1:0]  wp_dec;
  logic [ADDR_BITS-1:0]  ptr_dec;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  ring_we;
  logic [FRAME_BITS-1:0] tick_val;
  logic [FRAME_BITS-1:0] t;

  logic [FRAME_BITS-1:0] d_fwd;
  logic [FRAME_BITS-1:0] d_rev;
  logic                  neg;
  logic [FRAME_BITS-1:0] ad;
  logic [DIFF_BITS-1:0]  diff;
  logic                  take;
  logic                  brk;

  logic                  ab_hi_zero;
  logic [RB-1:0]         ab_lo;
  logic [WB-1:0]         ab25;
  logic [WB-1:0]         r3;
  logic                  match_ok;

  logic                  div_start;
  logic                  div_done;
  logic [MB-1:0]         quotient;
  logic [MB-1:0]         ms_val;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire = in_ch.valid & in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign out_ch.valid = out_valid;
  assign out_ch.offset_frames = out_frames;
  assign out_ch.offset_ms_q8 = out_ms;

  assign wp_dec = (wp == '0) ? ADDR_BITS'(RING_DEPTH - 1) : wp - 1'b1;
  assign ptr_dec = (scan_ptr == '0) ? ADDR_BITS'(RING_DEPTH - 1) : scan_ptr - 1'b1;
  assign rd_addr = (state == ST_SCAN) ? ptr_dec : wp_dec;

  assign ring_we = in_fire && enabled && (in_ch.command == otm_pkg::CMD_TICK);
  assign tick_val = in_ch.frame + FRAME_BITS'(in_ch.sample_offset);

  otm_ring #(
    .RING_DEPTH(RING_DEPTH),
    .FRAME_BITS(FRAME_BITS)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .wr_addr (wp),
    .wr_data (tick_val),
    .rd_addr (rd_addr),
    .rd_data (t)
  );

  // distance of the entry read this cycle
  assign d_fwd = onset - t;
  assign d_rev = t - onset;
  assign neg = onset < t;
  assign ad = neg ? d_rev : d_fwd;
  assign diff = DIFF_BITS'(onset) - DIFF_BITS'(t);
  assign take = !have || (ad < best_abs);
  assign brk = ((DIFF_BITS'(t) + DIFF_BITS'(rate)) < DIFF_BITS'(onset)) &&
               (ad > FRAME_BITS'(rate));

  // above 2^19 the window test fails for any rate
  assign ab_hi_zero = (best_abs[FRAME_BITS-1:RB] == '0);
  assign ab_lo = best_abs[RB-1:0];
  assign ab25 = WB'(ab_lo) * otm_pkg::WIN_DEN;
  assign r3 = WB'(rate) * otm_pkg::WIN_NUM;
  assign match_ok = (best_tick != '0) && (best_tick != last_matched) &&
                    ab_hi_zero && !(ab25 > r3);

  assign div_start = (state == ST_LOAD);

  otm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (rate),
    .done     (div_done),
    .quotient (quotient)
  );

  assign ms_val = best_diff[DIFF_BITS-1] ? (MB'(0) - quotient) : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
      rate    <= otm_pkg::DEFAULT_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        otm_pkg::REG_ENABLED: begin
          enabled <= cfg_data[0];
        end
        otm_pkg::REG_SAMPLE_RATE: begin
          rate <= (cfg_data == '0) ? otm_pkg::DEFAULT_RATE : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      count        <= '0;
      last_matched <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.command == otm_pkg::CMD_CLEAR) begin
              wp           <= '0;
              count        <= '0;
              last_matched <= '0;
            end else if (enabled && in_ch.command == otm_pkg::CMD_TICK) begin
              wp <= (wp == ADDR_BITS'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
              if (count != CNT_BITS'(RING_DEPTH)) begin
                count <= count + 1'b1;
              end
            end else if (enabled && in_ch.command == otm_pkg::CMD_ONSET &&
                         count != '0) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (brk || scan_left == '0) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= match_ok ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            last_matched <= best_tick;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // scan and result datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      onset     <= in_ch.frame;
      scan_ptr  <= wp_dec;
      scan_left <= count - 1'b1;
      have      <= 1'b0;
    end
    if (state == ST_SCAN) begin
      scan_ptr  <= ptr_dec;
      scan_left <= scan_left - 1'b1;
      have      <= 1'b1;
      if (take) begin
        best_abs  <= ad;
        best_diff <= diff;
        best_tick <= t;
      end
    end
    if (state == ST_CHECK) begin
      num <= NB'(ab_lo) * NB'(otm_pkg::MS_SCALE);
    end
    if (state == ST_EMIT && out_free) begin
      out_frames <= best_diff;
      out_ms     <= ms_val;
    end
  end

endmodule
